// ===== design/tfn_pkg.sv =====
// Shared types, widths and constants for the triangle flat normal block.
`timescale 1ns / 1ps

package tfn_pkg;

   // Field widths fixed by the interface.
   localparam int COORD_W = 20;
   localparam int FRAC_W  = 15;
   localparam int NORM_W  = FRAC_W + 1;

   // Internal widths of the cross product and the squared length.
   localparam int EDGE_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = PROD_W;
   localparam int HALF_W  = MAG_W / 2;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 2;

   // Digit recurrence widths: q = floor(sqrt(c^2 * 2^SHIFT / s)) < 2^Q_W.
   localparam int Q_W     = FRAC_W + 2;
   localparam int SHIFT   = 2 * FRAC_W + 2;
   localparam int REM_W   = SUM_W + 2 * Q_W + 2;
   localparam int PRD_W   = SUM_W + Q_W;

   // Largest magnitude of a normal component.
   localparam logic [Q_W-1:0] K_MAX = Q_W'((1 << FRAC_W) - 1);

   // Cycles from an accepted item to its result strobe.
   localparam int LATENCY = 3 + 3 + Q_W + 1;

   // One triangle.
   typedef struct packed {
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] z0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] z1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic signed [COORD_W-1:0] z2;
   } req_type;

   // One unit normal.
   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     degenerate;
   } rsp_type;

endpackage

// ===== design/tfn_cross.sv =====
// Three-stage cross product of both edge vectors, as sign and magnitude.
`timescale 1ns / 1ps

module tfn_cross (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  tfn_pkg::req_type                      req,
   output logic                                  out_valid,
   output logic [2:0][tfn_pkg::MAG_W-1:0]        mag,
   output logic [2:0]                            neg
);

   logic signed [tfn_pkg::EDGE_W-1:0] ea_in [3];
   logic signed [tfn_pkg::EDGE_W-1:0] eb_in [3];
   logic signed [tfn_pkg::EDGE_W-1:0] ea_ff [3];
   logic signed [tfn_pkg::EDGE_W-1:0] eb_ff [3];
   logic signed [tfn_pkg::PROD_W-1:0] pp_in [3][2];
   logic signed [tfn_pkg::PROD_W-1:0] pp_ff [3][2];
   logic signed [tfn_pkg::CROSS_W-1:0] diff [3];
   logic [2:0][tfn_pkg::MAG_W-1:0]    mag_in;
   logic [2:0][tfn_pkg::MAG_W-1:0]    mag_ff;
   logic [2:0]                        neg_in;
   logic [2:0]                        neg_ff;
   logic [2:0]                        vld_ff;

   // Edge vectors from the first vertex, sign extended by one bit.
   always_comb begin
      ea_in[0] = {req.x1[tfn_pkg::COORD_W-1], req.x1} - {req.x0[tfn_pkg::COORD_W-1], req.x0};
      ea_in[1] = {req.y1[tfn_pkg::COORD_W-1], req.y1} - {req.y0[tfn_pkg::COORD_W-1], req.y0};
      ea_in[2] = {req.z1[tfn_pkg::COORD_W-1], req.z1} - {req.z0[tfn_pkg::COORD_W-1], req.z0};
      eb_in[0] = {req.x2[tfn_pkg::COORD_W-1], req.x2} - {req.x0[tfn_pkg::COORD_W-1], req.x0};
      eb_in[1] = {req.y2[tfn_pkg::COORD_W-1], req.y2} - {req.y0[tfn_pkg::COORD_W-1], req.y0};
      eb_in[2] = {req.z2[tfn_pkg::COORD_W-1], req.z2} - {req.z0[tfn_pkg::COORD_W-1], req.z0};
   end

   // Six products, one multiplier each.
   always_comb begin
      pp_in[0][0] = ea_ff[1] * eb_ff[2];
      pp_in[0][1] = ea_ff[2] * eb_ff[1];
      pp_in[1][0] = ea_ff[2] * eb_ff[0];
      pp_in[1][1] = ea_ff[0] * eb_ff[2];
      pp_in[2][0] = ea_ff[0] * eb_ff[1];
      pp_in[2][1] = ea_ff[1] * eb_ff[0];
   end

   // Differences split into sign and magnitude.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]   = tfn_pkg::CROSS_W'(pp_ff[i][0]) - tfn_pkg::CROSS_W'(pp_ff[i][1]);
         neg_in[i] = diff[i][tfn_pkg::CROSS_W-1];
         mag_in[i] = neg_in[i] ? tfn_pkg::MAG_W'(-diff[i]) : tfn_pkg::MAG_W'(diff[i]);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ea_ff  <= ea_in;
      eb_ff  <= eb_in;
      pp_ff  <= pp_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[2];
   assign mag       = mag_ff;
   assign neg       = neg_ff;

endmodule

// ===== design/tfn_square.sv =====
// Three-stage squares of the cross components and their sum.
`timescale 1ns / 1ps

module tfn_square (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [2:0][tfn_pkg::MAG_W-1:0]   mag,
   input  logic [2:0]                       neg,
   output logic                             out_valid,
   output logic [2:0][tfn_pkg::SQ_W-1:0]    sq,
   output logic [tfn_pkg::SUM_W-1:0]        sum,
   output logic [2:0]                       out_neg,
   output logic                             deg
);

   logic [2*tfn_pkg::HALF_W-1:0] hh_ff [3];
   logic [2*tfn_pkg::HALF_W-1:0] hl_ff [3];
   logic [2*tfn_pkg::HALF_W-1:0] ll_ff [3];
   logic [2:0][tfn_pkg::SQ_W-1:0] sq_in;
   logic [2:0][tfn_pkg::SQ_W-1:0] sq_a_ff;
   logic [2:0][tfn_pkg::SQ_W-1:0] sq_b_ff;
   logic [tfn_pkg::SUM_W-1:0]     sum_in;
   logic [tfn_pkg::SUM_W-1:0]     sum_ff;
   logic [2:0]                    neg_a_ff;
   logic [2:0]                    neg_b_ff;
   logic [2:0]                    neg_c_ff;
   logic                          deg_ff;
   logic [2:0]                    vld_ff;

   // Half-word partial products of each square.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         hh_ff[i] <= mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]
                   * mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W];
         hl_ff[i] <= mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]
                   * mag[i][tfn_pkg::HALF_W-1:0];
         ll_ff[i] <= mag[i][tfn_pkg::HALF_W-1:0] * mag[i][tfn_pkg::HALF_W-1:0];
      end
      neg_a_ff <= neg;
   end

   // Recombine the partial products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (tfn_pkg::SQ_W'(hh_ff[i]) << (2 * tfn_pkg::HALF_W))
                  + (tfn_pkg::SQ_W'(hl_ff[i]) << (tfn_pkg::HALF_W + 1))
                  + tfn_pkg::SQ_W'(ll_ff[i]);
      end
   end

   // Squared length of the cross product.
   always_comb begin
      sum_in = tfn_pkg::SUM_W'(sq_a_ff[0]) + tfn_pkg::SUM_W'(sq_a_ff[1])
             + tfn_pkg::SUM_W'(sq_a_ff[2]);
   end

   always_ff @(posedge clock) begin
      sq_a_ff  <= sq_in;
      neg_b_ff <= neg_a_ff;
      sq_b_ff  <= sq_a_ff;
      sum_ff   <= sum_in;
      neg_c_ff <= neg_b_ff;
      deg_ff   <= (sq_a_ff[0] == '0) && (sq_a_ff[1] == '0) && (sq_a_ff[2] == '0);
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[2];
   assign sq        = sq_b_ff;
   assign sum       = sum_ff;
   assign out_neg   = neg_c_ff;
   assign deg       = deg_ff;

endmodule

// ===== design/tfn_root.sv =====
// Digit recurrence pipeline: one bit of q = floor(sqrt(c^2 * 2^SHIFT / s)) per stage.
`timescale 1ns / 1ps

module tfn_root (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [2:0][tfn_pkg::SQ_W-1:0]    sq,
   input  logic [tfn_pkg::SUM_W-1:0]        sum,
   input  logic [2:0]                       neg,
   input  logic                             deg,
   output logic                             out_valid,
   output logic [2:0][tfn_pkg::Q_W-1:0]     quo,
   output logic [2:0]                       out_neg,
   output logic                             out_deg
);

   localparam int N = tfn_pkg::Q_W;

   logic [2:0][tfn_pkg::REM_W-1:0] rem_ff [N];
   logic [2:0][tfn_pkg::PRD_W-1:0] prd_ff [N];
   logic [2:0][tfn_pkg::Q_W-1:0]   quo_ff [N];
   logic [tfn_pkg::SUM_W-1:0]      sum_ff [N];
   logic [2:0]                     neg_ff [N];
   logic                           deg_ff [N];
   logic                           vld_ff [N];

   for (genvar g = 0; g < N; g++) begin : g_stage
      localparam int J = N - 1 - g;

      logic [2:0][tfn_pkg::REM_W-1:0] rem_src;
      logic [2:0][tfn_pkg::PRD_W-1:0] prd_src;
      logic [2:0][tfn_pkg::Q_W-1:0]   quo_src;
      logic [tfn_pkg::SUM_W-1:0]      sum_src;
      logic [2:0]                     neg_src;
      logic                           deg_src;
      logic                           vld_src;
      logic [2:0][tfn_pkg::REM_W-1:0] trial;
      logic [2:0][tfn_pkg::REM_W-1:0] rem_in;
      logic [2:0][tfn_pkg::PRD_W-1:0] prd_in;
      logic [2:0][tfn_pkg::Q_W-1:0]   quo_in;

      // The first stage starts from R = c^2 * 2^SHIFT, P = 0, q = 0.
      if (g == 0) begin : g_head
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               rem_src[l] = tfn_pkg::REM_W'(sq[l]) << tfn_pkg::SHIFT;
               prd_src[l] = '0;
               quo_src[l] = '0;
            end
            sum_src = sum;
            neg_src = neg;
            deg_src = deg;
            vld_src = in_valid;
         end
      end else begin : g_body
         always_comb begin
            rem_src = rem_ff[g-1];
            prd_src = prd_ff[g-1];
            quo_src = quo_ff[g-1];
            sum_src = sum_ff[g-1];
            neg_src = neg_ff[g-1];
            deg_src = deg_ff[g-1];
            vld_src = vld_ff[g-1];
         end
      end

      // Try bit J: (q + 2^J)^2 s - q^2 s = 2^(J+1) P + 2^(2J) s, with P = q s.
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            trial[l] = (tfn_pkg::REM_W'(prd_src[l]) << (J + 1))
                     + (tfn_pkg::REM_W'(sum_src) << (2 * J));
            if (rem_src[l] >= trial[l]) begin
               rem_in[l] = rem_src[l] - trial[l];
               prd_in[l] = prd_src[l] + (tfn_pkg::PRD_W'(sum_src) << J);
               quo_in[l] = quo_src[l] | (tfn_pkg::Q_W'(1) << J);
            end else begin
               rem_in[l] = rem_src[l];
               prd_in[l] = prd_src[l];
               quo_in[l] = quo_src[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g] <= rem_in;
         prd_ff[g] <= prd_in;
         quo_ff[g] <= quo_in;
         sum_ff[g] <= sum_src;
         neg_ff[g] <= neg_src;
         deg_ff[g] <= deg_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign quo       = quo_ff[N-1];
   assign out_neg   = neg_ff[N-1];
   assign out_deg   = deg_ff[N-1];

endmodule

// ===== design/tfn_round.sv =====
// Output stage: round half away from zero, clamp, apply sign, register the item.
`timescale 1ns / 1ps

module tfn_round (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [2:0][tfn_pkg::Q_W-1:0]     quo,
   input  logic [2:0]                       neg,
   input  logic                             deg,
   output logic                             rsp_strobe,
   output tfn_pkg::rsp_type                 rsp_data
);

   logic [2:0][tfn_pkg::Q_W-1:0]    k;
   logic [2:0][tfn_pkg::NORM_W-1:0] comp;
   tfn_pkg::rsp_type                rsp_in;
   tfn_pkg::rsp_type                rsp_ff;
   logic                            strobe_ff;

   // k = (q + 1) / 2 is the largest k with (2k - 1)^2 s <= 4 c^2 2^(2F).
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         k[l] = (quo[l] + tfn_pkg::Q_W'(1)) >> 1;
         if (k[l] > tfn_pkg::K_MAX) begin
            k[l] = tfn_pkg::K_MAX;
         end
         if (deg) begin
            comp[l] = '0;
         end else if (neg[l]) begin
            comp[l] = -tfn_pkg::NORM_W'(k[l]);
         end else begin
            comp[l] = tfn_pkg::NORM_W'(k[l]);
         end
      end
      rsp_in.normal_x   = comp[0];
      rsp_in.normal_y   = comp[1];
      rsp_in.normal_z   = comp[2];
      rsp_in.degenerate = deg;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/triangle_flat_normal_top.sv =====
// Top level of the triangle flat normal pipeline.
`timescale 1ns / 1ps

// Stages from the accepting edge to the edge that takes the result
// (3 cross product, 3 squaring, 17 digit recurrence stages, 1 output stage).
// Throughput: one item per cycle; busy is low except in reset, and the result
// strobe is never held off. Synchronous reset clears every valid bit, so no
// result appears for items that were in flight.
module triangle_flat_normal_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tfn_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tfn_pkg::rsp_type rsp_data
);

   logic                             acc;
   logic                             x_valid;
   logic [2:0][tfn_pkg::MAG_W-1:0]   x_mag;
   logic [2:0]                       x_neg;
   logic                             s_valid;
   logic [2:0][tfn_pkg::SQ_W-1:0]    s_sq;
   logic [tfn_pkg::SUM_W-1:0]        s_sum;
   logic [2:0]                       s_neg;
   logic                             s_deg;
   logic                             r_valid;
   logic [2:0][tfn_pkg::Q_W-1:0]     r_quo;
   logic [2:0]                       r_neg;
   logic                             r_deg;

   assign busy = reset;
   assign acc  = start && !busy;

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc),
      .req       (req_data),
      .out_valid (x_valid),
      .mag       (x_mag),
      .neg       (x_neg)
   );

   tfn_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x_valid),
      .mag       (x_mag),
      .neg       (x_neg),
      .out_valid (s_valid),
      .sq        (s_sq),
      .sum       (s_sum),
      .out_neg   (s_neg),
      .deg       (s_deg)
   );

   tfn_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .sq        (s_sq),
      .sum       (s_sum),
      .neg       (s_neg),
      .deg       (s_deg),
      .out_valid (r_valid),
      .quo       (r_quo),
      .out_neg   (r_neg),
      .out_deg   (r_deg)
   );

   tfn_round u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (r_valid),
      .quo        (r_quo),
      .neg        (r_neg),
      .deg        (r_deg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // Every accepted item leaves after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      acc |-> ##(tfn_pkg::LATENCY) rsp_strobe)
      else $error("item did not leave after the pipeline latency");

   // A degenerate triangle gives the zero vector.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.degenerate |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("degenerate item carries a nonzero normal");

   // A proper triangle has at least one nonzero component.
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.degenerate |->
         rsp_data.normal_x != '0 || rsp_data.normal_y != '0 || rsp_data.normal_z != '0)
      else $error("proper triangle gave a zero normal");

   // Components stay within the clamp.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.normal_x != 16'sh8000 && rsp_data.normal_y != 16'sh8000
         && rsp_data.normal_z != 16'sh8000)
      else $error("normal component outside the clamp");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the triangle flat normal pipeline.
`timescale 1ns / 1ps

module tb;

   localparam int N_RANDOM = 1430;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   tfn_pkg::req_type req_data;
   logic             rsp_strobe;
   tfn_pkg::rsp_type rsp_data;

   tfn_pkg::rsp_type normal_queue[$];
   int      error_count;
   int      sent_count;
   int      degenerate_count;
   int      checked_count;

   // One directed triangle, with its normal typed in where it is obvious.
   typedef struct {
      tfn_pkg::req_type tri_in;
      bit               has_known;
      tfn_pkg::rsp_type known;
   } directed_row_type;

   directed_row_type directed[$];

   triangle_flat_normal_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("** triangle_flat_normal_top: FAILED **");
      $finish;
   end

   // Largest k with 4*c^2*2^(2F) >= (2k-1)^2 * s, clamped to the Q1.15 maximum.
   function automatic logic [15:0] unit_magnitude(logic [63:0] c, logic [159:0] s);
      logic [159:0] lhs;
      logic [159:0] rhs;
      logic [159:0] odd;
      int           lo;
      int           hi;
      int           mid;
      lo  = 0;
      hi  = (1 << tfn_pkg::FRAC_W) - 1;
      lhs = (160'(c) * 160'(c)) << (2 * tfn_pkg::FRAC_W + 2);
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 160'(2 * mid - 1);
         rhs = odd * odd * s;
         if (lhs >= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return 16'(lo);
   endfunction

   // Exact cross product of both edge vectors, scaled to unit length.
   function automatic tfn_pkg::rsp_type face_normal(tfn_pkg::req_type t);
      longint           ax, ay, az, bx, by, bz;
      longint           n[3];
      logic [63:0]      m[3];
      logic [159:0]     s;
      logic [15:0]      k;
      tfn_pkg::rsp_type r;
      ax = longint'(t.x1) - longint'(t.x0);
      ay = longint'(t.y1) - longint'(t.y0);
      az = longint'(t.z1) - longint'(t.z0);
      bx = longint'(t.x2) - longint'(t.x0);
      by = longint'(t.y2) - longint'(t.y0);
      bz = longint'(t.z2) - longint'(t.z0);
      n[0] = ay * bz - az * by;
      n[1] = az * bx - ax * bz;
      n[2] = ax * by - ay * bx;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
         s = s + 160'(m[i]) * 160'(m[i]);
      end
      r = '0;
      if (s == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      k = unit_magnitude(m[0], s);
      r.normal_x = (n[0] < 0) ? -k : k;
      k = unit_magnitude(m[1], s);
      r.normal_y = (n[1] < 0) ? -k : k;
      k = unit_magnitude(m[2], s);
      r.normal_z = (n[2] < 0) ? -k : k;
      return r;
   endfunction

   function automatic tfn_pkg::req_type make_tri(int a0, int b0, int c0, int a1, int b1,
                                                 int c1, int a2, int b2, int c2);
      tfn_pkg::req_type t;
      t.x0 = tfn_pkg::COORD_W'(a0); t.y0 = tfn_pkg::COORD_W'(b0);
      t.z0 = tfn_pkg::COORD_W'(c0);
      t.x1 = tfn_pkg::COORD_W'(a1); t.y1 = tfn_pkg::COORD_W'(b1);
      t.z1 = tfn_pkg::COORD_W'(c1);
      t.x2 = tfn_pkg::COORD_W'(a2); t.y2 = tfn_pkg::COORD_W'(b2);
      t.z2 = tfn_pkg::COORD_W'(c2);
      return t;
   endfunction

   function automatic tfn_pkg::rsp_type make_normal(int nx, int ny, int nz, bit deg);
      tfn_pkg::rsp_type r;
      r.normal_x   = tfn_pkg::NORM_W'(nx);
      r.normal_y   = tfn_pkg::NORM_W'(ny);
      r.normal_z   = tfn_pkg::NORM_W'(nz);
      r.degenerate = deg;
      return r;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(tfn_pkg::req_type t, bit has_known,
                                   tfn_pkg::rsp_type known);
      directed_row_type row;
      row.tri_in    = t;
      row.has_known = has_known;
      row.known     = known;
      directed      = {directed, row};
   endfunction

   function automatic int any_coord();
      return int'($urandom_range((1 << tfn_pkg::COORD_W) - 1, 0))
             - (1 << (tfn_pkg::COORD_W - 1));
   endfunction

   function automatic int near_coord(int base, int spread);
      int v;
      v = base + int'($urandom_range(2 * spread, 0)) - spread;
      if (v > (1 << (tfn_pkg::COORD_W - 1)) - 1) v = (1 << (tfn_pkg::COORD_W - 1)) - 1;
      if (v < -(1 << (tfn_pkg::COORD_W - 1))) v = -(1 << (tfn_pkg::COORD_W - 1));
      return v;
   endfunction

   // Random triangle: mostly well-formed faces, with collinear and coincident ones mixed in.
   function automatic tfn_pkg::req_type random_tri();
      tfn_pkg::req_type t;
      logic [191:0]     raw;
      int               kind;
      int               bx, by, bz, dx, dy, dz, f, spread;
      kind = int'($urandom_range(9, 0));
      case (kind) inside
         [0:2]: begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            t = raw[$bits(tfn_pkg::req_type)-1:0];
         end
         [3:5]: begin
            spread = 1 << $urandom_range(tfn_pkg::COORD_W - 2, 1);
            bx = any_coord(); by = any_coord(); bz = any_coord();
            t = make_tri(bx, by, bz,
                         near_coord(bx, spread), near_coord(by, spread), near_coord(bz, spread),
                         near_coord(bx, spread), near_coord(by, spread), near_coord(bz, spread));
         end
         6: begin
            // Tiny faces of up to two steps per coordinate on each edge.
            bx = any_coord(); by = any_coord(); bz = any_coord();
            t = make_tri(bx, by, bz,
                         near_coord(bx, 2), near_coord(by, 2), near_coord(bz, 2),
                         near_coord(bx, 2), near_coord(by, 2), near_coord(bz, 2));
         end
         7: begin
            // Collinear vertices along a random direction.
            bx = near_coord(0, 1 << 18); by = near_coord(0, 1 << 18); bz = near_coord(0, 1 << 18);
            dx = near_coord(0, 1 << 10); dy = near_coord(0, 1 << 10); dz = near_coord(0, 1 << 10);
            f  = int'($urandom_range(6, 0)) - 3;
            t = make_tri(bx, by, bz, bx + dx, by + dy, bz + dz,
                         bx + f * dx, by + f * dy, bz + f * dz);
         end
         8: begin
            // Two or three coincident vertices.
            bx = any_coord(); by = any_coord(); bz = any_coord();
            t = make_tri(bx, by, bz, bx, by, bz, any_coord(), any_coord(), any_coord());
            if ($urandom_range(1, 0) == 1) begin
               t.x2 = tfn_pkg::COORD_W'(bx);
               t.y2 = tfn_pkg::COORD_W'(by);
               t.z2 = tfn_pkg::COORD_W'(bz);
            end
         end
         default: begin
            // Face lying in a plane of two axes.
            bz = any_coord();
            t = make_tri(any_coord(), any_coord(), bz, any_coord(), any_coord(), bz,
                         any_coord(), any_coord(), bz);
         end
      endcase
      return t;
   endfunction

   // Drive one item, hold it until accepted, and record the normal it should give.
   task automatic send_tri(tfn_pkg::req_type t, bit has_known, tfn_pkg::rsp_type known);
      int gap;
      gap = $urandom_range(13, 0);
      if ($urandom_range(3, 0) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy);
      if (has_known) begin
         normal_queue = {normal_queue, known};
      end else begin
         normal_queue = {normal_queue, face_normal(t)};
      end
      sent_count++;
   endtask

   // Compare every strobed normal with the oldest one still owed.
   always @(posedge clock) begin
      tfn_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (normal_queue.size() == 0) begin
            $error("unexpected normal %p", rsp_data);
            error_count++;
         end else begin
            want = normal_queue.pop_front();
            checked_count++;
            if (rsp_data.degenerate) degenerate_count++;
            if (rsp_data.normal_x !== want.normal_x) begin
               $error("normal_x expected %0d got %0d", want.normal_x, rsp_data.normal_x);
               error_count++;
            end
            if (rsp_data.normal_y !== want.normal_y) begin
               $error("normal_y expected %0d got %0d", want.normal_y, rsp_data.normal_y);
               error_count++;
            end
            if (rsp_data.normal_z !== want.normal_z) begin
               $error("normal_z expected %0d got %0d", want.normal_z, rsp_data.normal_z);
               error_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate expected %0b got %0b", want.degenerate, rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   initial begin
      int               lo_c;
      int               hi_c;
      int               wait_cycles;
      tfn_pkg::rsp_type none;
      lo_c = -(1 << (tfn_pkg::COORD_W - 1));
      hi_c = (1 << (tfn_pkg::COORD_W - 1)) - 1;
      none = '0;
      error_count = 0;
      sent_count = 0;
      degenerate_count = 0;
      checked_count = 0;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed faces: degenerate cases, unit axes, both winding orders and the range extremes.
      add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_normal(0, 0, 0, 1));
      add_row(make_tri(lo_c, lo_c, lo_c, lo_c, lo_c, lo_c, lo_c, lo_c, lo_c), 1,
              make_normal(0, 0, 0, 1));
      add_row(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2), 1, make_normal(0, 0, 0, 1));
      add_row(make_tri(lo_c, lo_c, lo_c, 0, 0, 0, hi_c, hi_c, hi_c), 0, none);
      add_row(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 1, make_normal(0, 0, 32767, 0));
      add_row(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0), 1, make_normal(0, 0, -32767, 0));
      add_row(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1), 1, make_normal(32767, 0, 0, 0));
      add_row(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0), 1, make_normal(0, 32767, 0, 0));
      add_row(make_tri(lo_c, lo_c, 0, hi_c, lo_c, 0, lo_c, hi_c, 0), 1,
              make_normal(0, 0, 32767, 0));
      add_row(make_tri(hi_c, hi_c, 0, lo_c, hi_c, 0, hi_c, lo_c, 0), 1,
              make_normal(0, 0, 32767, 0));
      add_row(make_tri(lo_c, 0, lo_c, lo_c, 0, hi_c, hi_c, 0, lo_c), 1,
              make_normal(0, 32767, 0, 0));
      add_row(make_tri(lo_c, lo_c, lo_c, hi_c, lo_c, lo_c, lo_c, hi_c, hi_c), 0, none);
      add_row(make_tri(hi_c, lo_c, hi_c, lo_c, hi_c, lo_c, hi_c, hi_c, lo_c), 0, none);
      add_row(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1), 0, none);
      add_row(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 2), 0, none);
      add_row(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 5), 0, none);
      add_row(make_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1), 0, none);
      add_row(make_tri(0, 0, 0, hi_c, 1, 0, 1, hi_c, 1), 0, none);
      add_row(make_tri(12345, -6789, 4242, -524288, 524287, 1, 7, -7, 524287), 0, none);
      add_row(make_tri(0, 0, 0, 1, 2, 3, 3, 2, 1), 0, none);

      foreach (directed[i]) begin
         send_tri(directed[i].tri_in, directed[i].has_known, directed[i].known);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         send_tri(random_tri(), 1'b0, none);
         // Once midway, drain the pipeline completely before going on.
         if (i == N_RANDOM / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (normal_queue.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (normal_queue.size() != 0 && wait_cycles < 10 * tfn_pkg::LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (tfn_pkg::LATENCY + 4) @(posedge clock);

      $display("Sent %0d triangles, checked %0d normals, %0d of them degenerate.",
               sent_count, checked_count, degenerate_count);
      $display("Mix: directed extremes, random, small, tiny, collinear, coincident, planar.");
      if (error_count == 0 && normal_queue.size() == 0) begin
         $display("** triangle_flat_normal_top: PASSED **");
      end else begin
         $display("** triangle_flat_normal_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tfn_pkg.sv
design/tfn_cross.sv
design/tfn_square.sv
design/tfn_root.sv
design/tfn_round.sv
design/triangle_flat_normal_top.sv
sim/tb.sv
